### hdl/tweakable_10bit_block_cipher_macros.svh
// Assertion macros used by the checker file of the tweakable block cipher
`ifndef TWEAKABLE_10BIT_BLOCK_CIPHER_MACROS_SVH
`define TWEAKABLE_10BIT_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, gated off while rstn is low
`define TBC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while rstn is low
`define TBC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tbc_pkg.sv
// Shared constants, types and cipher functions for the tweakable 10-bit block cipher
package tbc_pkg;

    localparam int BLOCK_W     = 10;
    localparam int HALF_W      = 5;
    localparam int TWEAK_W     = 48;
    localparam int KEY_W       = 60;
    localparam int RKEY_W      = 30;
    localparam int GKEY_W      = 25;
    localparam int NIBBLES     = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 2;

    // Rotation amounts of the 60-bit diffusion
    localparam int DIFF_ROT_0 = 6;
    localparam int DIFF_ROT_1 = 12;
    localparam int DIFF_ROT_2 = 19;
    localparam int DIFF_ROT_3 = 29;
    localparam int DIFF_ROT_4 = 43;
    localparam int DIFF_ROT_5 = 51;

    localparam logic [HALF_W-1:0] SBOX [32] = '{
        5'd0,  5'd2,  5'd4,  5'd12, 5'd8,  5'd14, 5'd24, 5'd21,
        5'd16, 5'd19, 5'd28, 5'd5,  5'd17, 5'd20, 5'd11, 5'd23,
        5'd1,  5'd6,  5'd7,  5'd26, 5'd25, 5'd18, 5'd10, 5'd27,
        5'd3,  5'd13, 5'd9,  5'd29, 5'd22, 5'd30, 5'd15, 5'd31
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_WORD_0 = 2'd0,
        CFG_KEY_WORD_1 = 2'd1,
        CFG_KEY_WORD_2 = 2'd2,
        CFG_KEY_WORD_3 = 2'd3
    } cfg_reg_t;

    // Item after the front end: block plus the first two schedule words
    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        logic [KEY_W-1:0]   sched_a;
        logic [KEY_W-1:0]   sched_b;
    } sched_t;

    function automatic logic [HALF_W-1:0] rot5(input logic [HALF_W-1:0] v, input int r);
        logic [2*HALF_W-1:0] dbl;
        dbl = {v, v} << r;
        return dbl[2*HALF_W-1:HALF_W];
    endfunction

    function automatic logic [HALF_W-1:0] gfun(input logic [HALF_W-1:0] v,
                                               input logic [GKEY_W-1:0] gk);
        logic [HALF_W-1:0] acc;
        acc = rot5(v, 1) & rot5(v, 2);
        for (int i = 0; i < 5; i++) begin
            acc = acc ^ (rot5(v, i) & gk[HALF_W*i +: HALF_W]);
        end
        return acc;
    endfunction

    function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] blk,
                                                     input logic [RKEY_W-1:0] rk,
                                                     input logic last_rnd);
        logic [HALF_W-1:0] l_half;
        logic [HALF_W-1:0] r_half;
        logic [HALF_W-1:0] sk;
        logic [HALF_W-1:0] nl;
        logic [HALF_W-1:0] nr;
        logic [GKEY_W-1:0] gk;
        l_half = blk[BLOCK_W-1:HALF_W];
        r_half = blk[HALF_W-1:0];
        gk     = rk[GKEY_W-1:0];
        sk     = rk[RKEY_W-1:GKEY_W];
        if (!last_rnd) begin
            nl = r_half ^ gfun(l_half, gk);
            nr = SBOX[l_half ^ sk];
        end else begin
            nr = r_half ^ gfun(l_half, gk);
            nl = SBOX[l_half] ^ sk;
        end
        return {nl, nr};
    endfunction

    function automatic logic [KEY_W-1:0] widen(input logic [TWEAK_W-1:0] t);
        logic [KEY_W-1:0] v;
        v = '0;
        for (int i = 0; i < NIBBLES; i++) begin
            v[HALF_W*i +: HALF_W] = {1'b0, t[4*i +: 4]};
        end
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] slayer(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] o;
        o = '0;
        for (int i = 0; i < NIBBLES; i++) begin
            o[HALF_W*i +: HALF_W] = SBOX[v[HALF_W*i +: HALF_W]];
        end
        return o;
    endfunction

    function automatic logic [KEY_W-1:0] rot60(input logic [KEY_W-1:0] v, input int r);
        logic [2*KEY_W-1:0] dbl;
        dbl = {v, v} << r;
        return dbl[2*KEY_W-1:KEY_W];
    endfunction

    function automatic logic [KEY_W-1:0] diffuse(input logic [KEY_W-1:0] v);
        return v ^ rot60(v, DIFF_ROT_0) ^ rot60(v, DIFF_ROT_1) ^ rot60(v, DIFF_ROT_2)
                 ^ rot60(v, DIFF_ROT_3) ^ rot60(v, DIFF_ROT_4) ^ rot60(v, DIFF_ROT_5);
    endfunction

    // Bit 12*row+col moves to 5*col+row
    function automatic logic [KEY_W-1:0] transpose(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] o;
        o = '0;
        for (int row = 0; row < HALF_W; row++) begin
            for (int col = 0; col < NIBBLES; col++) begin
                o[HALF_W*col + row] = v[NIBBLES*row + col];
            end
        end
        return o;
    endfunction

endpackage

### hdl/tbc_front.sv
// Front end: accept items and compute the first half of the tweak schedule
module tbc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tbc_pkg::BLOCK_W-1:0]         s_plain_block,
    input  logic [tbc_pkg::TWEAK_W-1:0]         s_tweak_value,
    input  logic [tbc_pkg::KEY_W-1:0]           key_word_0,
    input  logic [tbc_pkg::KEY_W-1:0]           key_word_1,
    output logic                                f_valid,
    input  logic                                f_ready,
    output tbc_pkg::sched_t                     f_item
);

    logic                       f_valid_reg;
    tbc_pkg::sched_t            f_item_reg;
    logic [tbc_pkg::KEY_W-1:0]  sched_a;
    logic [tbc_pkg::KEY_W-1:0]  sched_b;

    assign sched_a = tbc_pkg::widen(s_tweak_value) ^ key_word_0;
    assign sched_b = tbc_pkg::diffuse(tbc_pkg::slayer(sched_a)) ^ key_word_1;

    // Take a new item whenever the held one is empty or leaving
    assign s_ready = !f_valid_reg || f_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            f_item_reg.blk     <= s_plain_block;
            f_item_reg.sched_a <= sched_a;
            f_item_reg.sched_b <= sched_b;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_item  = f_item_reg;

endmodule

### hdl/tbc_queue.sv
// Short queue between front and back end, with a registered head entry
module tbc_queue #(
    parameter int DEPTH = tbc_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tbc_pkg::sched_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output tbc_pkg::sched_t  out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbc_pkg::sched_t   mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              head_valid_reg;
    tbc_pkg::sched_t   head_reg;

    logic push;
    logic head_load;
    logic mem_empty;
    logic mem_rd;
    logic bypass;
    logic mem_wr;

    assign mem_empty = (cnt_reg == '0);
    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign push      = in_valid && in_ready;
    assign head_load = !head_valid_reg || out_ready;
    assign mem_rd    = head_load && !mem_empty;
    // Pass straight to the head when nothing older waits
    assign bypass    = head_load && mem_empty && push;
    assign mem_wr    = push && !bypass;
    assign cnt_next  = cnt_reg + CNT_W'(mem_wr) - CNT_W'(mem_rd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (mem_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (mem_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (head_load) begin
                head_valid_reg <= !mem_empty || push;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            head_reg <= mem[rd_ptr_reg];
        end else if (bypass) begin
            head_reg <= in_item;
        end
    end

    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;

endmodule

### hdl/tbc_back.sv
// Back end: finish the tweak schedule and run the eight rounds over two stages
module tbc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tbc_pkg::sched_t                in_item,
    input  logic [tbc_pkg::KEY_W-1:0]      key_word_2,
    input  logic [tbc_pkg::KEY_W-1:0]      key_word_3,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tbc_pkg::BLOCK_W-1:0]    m_cipher_block
);

    localparam int KW = tbc_pkg::KEY_W;
    localparam int RW = tbc_pkg::RKEY_W;

    logic [KW-1:0]               sched_c;
    logic [KW-1:0]               sched_d;
    logic [tbc_pkg::BLOCK_W-1:0] blk_first;
    logic [tbc_pkg::BLOCK_W-1:0] blk_last;

    logic                        mid_valid_reg;
    logic [tbc_pkg::BLOCK_W-1:0] mid_blk_reg;
    logic [KW-1:0]               mid_c_reg;
    logic [KW-1:0]               mid_d_reg;
    logic                        out_valid_reg;
    logic [tbc_pkg::BLOCK_W-1:0] out_blk_reg;
    logic                        out_ready;

    assign sched_c = tbc_pkg::slayer(tbc_pkg::transpose(
                         tbc_pkg::slayer(in_item.sched_b) ^ key_word_2));
    assign sched_d = tbc_pkg::slayer(tbc_pkg::diffuse(sched_c) ^ key_word_3);

    // Rounds one to four use the schedule words that came from the front end
    always_comb begin
        blk_first = in_item.blk;
        blk_first = tbc_pkg::enc_round(blk_first, in_item.sched_a[RW-1:0], 1'b0);
        blk_first = tbc_pkg::enc_round(blk_first, in_item.sched_a[KW-1:RW], 1'b0);
        blk_first = tbc_pkg::enc_round(blk_first, in_item.sched_b[RW-1:0], 1'b0);
        blk_first = tbc_pkg::enc_round(blk_first, in_item.sched_b[KW-1:RW], 1'b0);
    end

    // Rounds five to seven, then the final round
    always_comb begin
        blk_last = mid_blk_reg;
        blk_last = tbc_pkg::enc_round(blk_last, mid_c_reg[RW-1:0], 1'b0);
        blk_last = tbc_pkg::enc_round(blk_last, mid_c_reg[KW-1:RW], 1'b0);
        blk_last = tbc_pkg::enc_round(blk_last, mid_d_reg[RW-1:0], 1'b0);
        blk_last = tbc_pkg::enc_round(blk_last, mid_d_reg[KW-1:RW], 1'b1);
    end

    assign out_ready = !out_valid_reg || m_ready;
    assign in_ready  = !mid_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mid_valid_reg <= in_valid;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mid_blk_reg <= blk_first;
            mid_c_reg   <= sched_c;
            mid_d_reg   <= sched_d;
        end
        if (mid_valid_reg && out_ready) begin
            out_blk_reg <= blk_last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_cipher_block = out_blk_reg;

endmodule

### hdl/tweakable_10bit_block_cipher.sv
// Top level of the tweakable 10-bit block cipher: key registers, front, queue and back end
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_plain_block[9:0], s_tweak_value[47:0]
//  m_        out        m_valid/m_ready    m_cipher_block[9:0]
//  cfg_      in         cfg_wr_en          cfg_index[1:0], cfg_data[59:0]
//
//  One item per cycle sustained while m_ready holds high; each item passes the front register,
//  the queue head and the two round stages, and waits longer while the queue holds items.
//  The queue holds QUEUE_DEPTH items besides its head, which the front end can still fill
//  after m_ready drops.
//  Reset is synchronous on aresetn low and clears all valid flags and keys to zero.
module tweakable_10bit_block_cipher #(
    parameter int QUEUE_DEPTH = tbc_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tbc_pkg::BLOCK_W-1:0]       s_plain_block,
    input  logic [tbc_pkg::TWEAK_W-1:0]       s_tweak_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tbc_pkg::BLOCK_W-1:0]       m_cipher_block,
    input  logic                              cfg_wr_en,
    input  logic [tbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tbc_pkg::KEY_W-1:0]         cfg_data
);

    logic [tbc_pkg::KEY_W-1:0] key_word_0_reg;
    logic [tbc_pkg::KEY_W-1:0] key_word_1_reg;
    logic [tbc_pkg::KEY_W-1:0] key_word_2_reg;
    logic [tbc_pkg::KEY_W-1:0] key_word_3_reg;

    logic             f_valid;
    logic             f_ready;
    tbc_pkg::sched_t  f_item;
    logic             q_valid;
    logic             q_ready;
    tbc_pkg::sched_t  q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_word_0_reg <= '0;
            key_word_1_reg <= '0;
            key_word_2_reg <= '0;
            key_word_3_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (tbc_pkg::cfg_reg_t'(cfg_index))
                tbc_pkg::CFG_KEY_WORD_0: key_word_0_reg <= cfg_data;
                tbc_pkg::CFG_KEY_WORD_1: key_word_1_reg <= cfg_data;
                tbc_pkg::CFG_KEY_WORD_2: key_word_2_reg <= cfg_data;
                tbc_pkg::CFG_KEY_WORD_3: key_word_3_reg <= cfg_data;
            endcase
        end
    end

    tbc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_plain_block (s_plain_block),
        .s_tweak_value (s_tweak_value),
        .key_word_0    (key_word_0_reg),
        .key_word_1    (key_word_1_reg),
        .f_valid       (f_valid),
        .f_ready       (f_ready),
        .f_item        (f_item)
    );

    tbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    tbc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_item        (q_item),
        .key_word_2     (key_word_2_reg),
        .key_word_3     (key_word_3_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cipher_block (m_cipher_block)
    );

endmodule

### hdl/tbc_checker.sv
// Port-level checker for the tweakable 10-bit block cipher, bound to the top level
`include "tweakable_10bit_block_cipher_macros.svh"

module tbc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [tbc_pkg::BLOCK_W-1:0]    m_cipher_block
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    // Items accepted whose results have not been transferred yet
    assign pend_next = pend_reg + 8'(s_valid && s_ready) - 8'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `TBC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_cipher_block), "result changed while stalled")
    `TBC_ASSERT_IMPL(a_no_spurious, aclk, aresetn, m_valid, pend_reg != 8'd0, "result without an accepted item")
    `TBC_ASSERT_IMPL(a_idle_accepts, aclk, aresetn, pend_reg == 8'd0, s_ready, "empty block refuses input")
    `TBC_ASSERT_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")

endmodule

bind tweakable_10bit_block_cipher tbc_checker u_tbc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_cipher_block (m_cipher_block)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the tweakable 10-bit block cipher
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 102;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_SPACING = 600;

    // 5-bit substitution table, entry 31 first
    localparam logic [159:0] SBOX5_TABLE = {
        5'd31, 5'd15, 5'd30, 5'd22, 5'd29, 5'd9,  5'd13, 5'd3,
        5'd27, 5'd10, 5'd18, 5'd25, 5'd26, 5'd7,  5'd6,  5'd1,
        5'd23, 5'd11, 5'd20, 5'd17, 5'd5,  5'd28, 5'd19, 5'd16,
        5'd21, 5'd24, 5'd14, 5'd8,  5'd12, 5'd4,  5'd2,  5'd0
    };

    typedef struct packed {
        logic [tbc_pkg::BLOCK_W-1:0] plain;
        logic [tbc_pkg::TWEAK_W-1:0] tweak;
    } block_req_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_mode_t;

    logic                              aclk           = 1'b0;
    logic                              aresetn        = 1'b0;
    logic                              s_valid        = 1'b0;
    logic                              s_ready;
    logic [tbc_pkg::BLOCK_W-1:0]       s_plain_block  = '0;
    logic [tbc_pkg::TWEAK_W-1:0]       s_tweak_value  = '0;
    logic                              m_valid;
    logic                              m_ready        = 1'b0;
    logic [tbc_pkg::BLOCK_W-1:0]       m_cipher_block;
    logic                              cfg_wr_en      = 1'b0;
    logic [tbc_pkg::CFG_INDEX_W-1:0]   cfg_index      = '0;
    logic [tbc_pkg::KEY_W-1:0]         cfg_data       = '0;

    logic [tbc_pkg::KEY_W-1:0]   key_words [4];
    block_req_t                  block_req_q [$];
    logic [tbc_pkg::BLOCK_W-1:0] cipher_due_q [$];

    int unsigned err_cnt      = 0;
    int unsigned blocks_sent  = 0;
    int unsigned blocks_seen  = 0;
    int unsigned key_settings = 0;
    int unsigned long_holds   = 0;
    int unsigned cycle_cnt    = 0;

    tweakable_10bit_block_cipher i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_plain_block  (s_plain_block),
        .s_tweak_value  (s_tweak_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cipher_block (m_cipher_block),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 aclk = ~aclk;

    // ---------------- cipher predictor ----------------

    function automatic logic [4:0] sbox5(input logic [4:0] x);
        int idx;
        idx = x;
        return SBOX5_TABLE[5*idx +: 5];
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] v, input int r);
        if (r == 0) return v;
        return (v << r) | (v >> (5 - r));
    endfunction

    function automatic logic [4:0] gmix(input logic [4:0] v, input logic [24:0] gk);
        logic [4:0] acc;
        acc = rotl5(v, 1) & rotl5(v, 2);
        for (int i = 0; i < 5; i++) acc ^= rotl5(v, i) & gk[5*i +: 5];
        return acc;
    endfunction

    function automatic logic [9:0] feistel_round(input logic [9:0] blk,
                                                 input logic [29:0] rk,
                                                 input bit last_round);
        logic [4:0] lh, rh, nl, nr;
        lh = blk[9:5];
        rh = blk[4:0];
        if (!last_round) begin
            nl = rh ^ gmix(lh, rk[24:0]);
            nr = sbox5(lh ^ rk[29:25]);
        end else begin
            nr = rh ^ gmix(lh, rk[24:0]);
            nl = sbox5(lh) ^ rk[29:25];
        end
        return {nl, nr};
    endfunction

    function automatic logic [59:0] spread_nibbles(input logic [47:0] t);
        logic [59:0] v;
        v = '0;
        for (int i = 0; i < 12; i++) v[5*i +: 5] = {1'b0, t[4*i +: 4]};
        return v;
    endfunction

    function automatic logic [59:0] sub_layer(input logic [59:0] v);
        logic [59:0] o;
        for (int i = 0; i < 12; i++) o[5*i +: 5] = sbox5(v[5*i +: 5]);
        return o;
    endfunction

    function automatic logic [59:0] rotl60(input logic [59:0] v, input int r);
        return (v << r) | (v >> (60 - r));
    endfunction

    function automatic logic [59:0] mix60(input logic [59:0] v);
        return v ^ rotl60(v, 6) ^ rotl60(v, 12) ^ rotl60(v, 19)
                 ^ rotl60(v, 29) ^ rotl60(v, 43) ^ rotl60(v, 51);
    endfunction

    function automatic logic [59:0] bit_transpose(input logic [59:0] v);
        logic [59:0] o;
        for (int i = 0; i < 60; i++) o[(i % 12) * 5 + i / 12] = v[i];
        return o;
    endfunction

    function automatic logic [9:0] encrypt_block(input logic [9:0] plain,
                                                 input logic [47:0] tweak);
        logic [59:0] a, b, c, d;
        logic [29:0] rk [8];
        logic [9:0]  blk;
        a = spread_nibbles(tweak) ^ key_words[tbc_pkg::CFG_KEY_WORD_0];
        b = mix60(sub_layer(a)) ^ key_words[tbc_pkg::CFG_KEY_WORD_1];
        c = sub_layer(bit_transpose(sub_layer(b) ^ key_words[tbc_pkg::CFG_KEY_WORD_2]));
        d = sub_layer(mix60(c) ^ key_words[tbc_pkg::CFG_KEY_WORD_3]);
        rk[0] = a[29:0]; rk[1] = a[59:30];
        rk[2] = b[29:0]; rk[3] = b[59:30];
        rk[4] = c[29:0]; rk[5] = c[59:30];
        rk[6] = d[29:0]; rk[7] = d[59:30];
        blk = plain;
        for (int i = 0; i < 7; i++) blk = feistel_round(blk, rk[i], 1'b0);
        return feistel_round(blk, rk[7], 1'b1);
    endfunction

    // ---------------- sender ----------------

    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        block_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cipher_due_q.push_back(encrypt_block(s_plain_block, s_tweak_value));
                blocks_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || block_req_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    req = block_req_q.pop_front();
                    s_valid       <= 1'b1;
                    s_plain_block <= req.plain;
                    s_tweak_value <= req.tweak;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ---------------- receiver and checker ----------------

    rx_mode_t    rx_mode      = RX_ALWAYS;
    int          mode_left    = 0;
    int          hold_left    = 0;
    int unsigned next_hold_at = 250;
    int unsigned rx_tick      = 0;

    always @(posedge aclk) begin
        logic [tbc_pkg::BLOCK_W-1:0] due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                blocks_seen++;
                if (cipher_due_q.size() == 0) begin
                    $error("cipher_block: no block outstanding, actual %h", m_cipher_block);
                    err_cnt++;
                end else begin
                    due = cipher_due_q.pop_front();
                    if (m_cipher_block !== due) begin
                        $error("cipher_block: expected %h actual %h", due, m_cipher_block);
                        err_cnt++;
                    end
                end
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (blocks_seen >= next_hold_at) begin
                // long hold-off: let the block fill and back-pressure the input
                hold_left = LONG_HOLD;
                next_hold_at += HOLD_SPACING;
                long_holds++;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:   m_ready <= ($urandom_range(0, 9) != 0);
                    default:     m_ready <= (rx_tick % 4 != 3);
                endcase
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("tweakable_10bit_block_cipher test failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic write_key(input tbc_pkg::cfg_reg_t idx, input logic [59:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        key_words[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_keys(input logic [59:0] k0, input logic [59:0] k1,
                            input logic [59:0] k2, input logic [59:0] k3);
        write_key(tbc_pkg::CFG_KEY_WORD_0, k0);
        write_key(tbc_pkg::CFG_KEY_WORD_1, k1);
        write_key(tbc_pkg::CFG_KEY_WORD_2, k2);
        write_key(tbc_pkg::CFG_KEY_WORD_3, k3);
    endtask

    function automatic logic [59:0] rand_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[59:0];
    endfunction

    function automatic block_req_t rand_block();
        block_req_t  r;
        logic [63:0] w;
        w = {$urandom, $urandom};
        r.tweak = w[47:0];
        r.plain = 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 15))
            0:       r.tweak = '0;
            1:       r.tweak = '1;
            2:       r.plain = '0;
            3:       r.plain = '1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic block_req_t mk_block(input logic [9:0] p, input logic [47:0] t);
        block_req_t r;
        r.plain = p;
        r.tweak = t;
        return r;
    endfunction

    // sample at the falling edge so queue and valid updates have settled
    task automatic wait_idle();
        while (block_req_q.size() != 0 || s_valid || cipher_due_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        for (int k = 0; k < 4; k++) key_words[k] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed blocks under the reset keys
        block_req_q.push_back(mk_block(10'h000, 48'h0));
        block_req_q.push_back(mk_block(10'h3FF, 48'hFFFF_FFFF_FFFF));
        block_req_q.push_back(mk_block(10'h3FF, 48'h0));
        block_req_q.push_back(mk_block(10'h3E0, 48'h0));
        block_req_q.push_back(mk_block(10'h01F, 48'hFFFF_FFFF_FFFF));
        block_req_q.push_back(mk_block(10'h155, 48'h5555_5555_5555));
        block_req_q.push_back(mk_block(10'h2AA, 48'hAAAA_AAAA_AAAA));
        // top nibble bits must never reach the fifth bit of a slot
        block_req_q.push_back(mk_block(10'h200, 48'h8888_8888_8888));
        block_req_q.push_back(mk_block(10'h001, 48'h1111_1111_1111));
        block_req_q.push_back(mk_block(10'h000, 48'h8000_0000_0000));
        block_req_q.push_back(mk_block(10'h001, 48'h0000_0000_0001));
        for (int i = 0; i < 12; i++)
            block_req_q.push_back(mk_block(10'((i * 85) & 10'h3FF), 48'hF << (4 * i)));
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_keys('1, '1, '1, '1);
                1: set_keys(60'h800_0000_0000_0000, 60'h800_0000_0000_0000,
                            60'h800_0000_0000_0000, 60'h800_0000_0000_0000);
                2: set_keys('0, '0, '0, '0);
                3: set_keys(60'h1, 60'h1, 60'h1, 60'h1);
                default: begin
                    // odd phases change one word only, the others must hold
                    if (p % 2) write_key(tbc_pkg::cfg_reg_t'((p >> 1) & 3), rand_key());
                    else set_keys(rand_key(), rand_key(), rand_key(), rand_key());
                end
            endcase
            key_settings++;
            @(negedge aclk);
            for (int i = 0; i < PHASE_ITEMS; i++) block_req_q.push_back(rand_block());
            wait_idle();
        end

        if (cipher_due_q.size() != 0) begin
            $error("cipher_block: %0d blocks never came out", cipher_due_q.size());
            err_cnt++;
        end
        $display("Encrypted %0d blocks (%0d checked) across %0d key settings,",
                 blocks_sent, blocks_seen, key_settings + 1);
        $display("with bursty input, random output stalls and %0d long hold-offs.",
                 long_holds);
        if (err_cnt == 0) begin
            $display("tweakable_10bit_block_cipher test passed");
        end else begin
            $display("tweakable_10bit_block_cipher test failed");
        end
        $finish;
    end

endmodule
